/* hdl/ipav_pkg.sv */
`default_nettype none
package ipav_pkg;

    // Character classes produced by the front end
    typedef enum logic [2:0] {
        CLS_END   = 3'd0,
        CLS_DEC   = 3'd1,
        CLS_HEXL  = 3'd2,
        CLS_COLON = 3'd3,
        CLS_DOT   = 3'd4,
        CLS_SPACE = 3'd5,
        CLS_OTHER = 3'd6
    } t_char_class;

    // One classified item as it travels through the queue
    typedef struct packed {
        t_char_class cls;
        logic [3:0]  digit;
    } t_item;

    // Parse phases
    typedef enum logic [2:0] {
        PH_BEFORE  = 3'd0,
        PH_ADDR    = 3'd1,
        PH_IPV4    = 3'd2,
        PH_IPV6    = 3'd3,
        PH_BETWEEN = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    // Verdict codes
    typedef enum logic [2:0] {
        VD_EMPTY      = 3'd0,
        VD_IPV4_DONE  = 3'd1,
        VD_IPV4_PART  = 3'd2,
        VD_IPV6_DONE  = 3'd3,
        VD_IPV6_PART  = 3'd4,
        VD_ERROR      = 3'd5
    } t_verdict;

    // Parser state
    typedef struct packed {
        t_phase     phase;
        logic [2:0] length;
        logic [8:0] value;
        logic [3:0] count;
        logic [1:0] dcc;
    } t_parse_state;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [2:0] LEN_MAX      = 3'd7;
    localparam logic [2:0] V6_GROUP_LEN = 3'd4;
    localparam logic [8:0] VALUE_SAT    = 9'd256;
    localparam logic [8:0] VALUE_MAX    = 9'd255;
    localparam logic [3:0] V4_GROUPS    = 4'd4;
    localparam logic [3:0] V6_GROUPS    = 4'd8;
    localparam logic [1:0] DCC_MAX      = 2'd1;

endpackage
`default_nettype wire

/* hdl/ipav_front.sv */
`default_nettype none
module ipav_front
    import ipav_pkg::*;
(
    input  wire logic [7:0] i_character,
    input  wire logic       i_end_of_string,
    output t_item           o_item
);

    logic is_dec;
    logic is_hexl;
    logic is_space;

    // Classify the character
    always_comb begin
        is_dec   = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
        is_hexl  = ((i_character >= CH_LO_A) && (i_character <= CH_LO_F)) ||
                   ((i_character >= CH_UP_A) && (i_character <= CH_UP_F));
        is_space = (i_character == CH_SPACE) ||
                   ((i_character >= CH_TAB) && (i_character <= CH_CR));
        o_item.digit = i_character[3:0];
        if (i_end_of_string || (i_character == CH_NUL)) begin
            o_item.cls = CLS_END;
        end else if (is_dec) begin
            o_item.cls = CLS_DEC;
        end else if (is_hexl) begin
            o_item.cls = CLS_HEXL;
        end else if (i_character == CH_COLON) begin
            o_item.cls = CLS_COLON;
        end else if (i_character == CH_DOT) begin
            o_item.cls = CLS_DOT;
        end else if (is_space) begin
            o_item.cls = CLS_SPACE;
        end else begin
            o_item.cls = CLS_OTHER;
        end
    end

endmodule
`default_nettype wire

/* hdl/ipav_queue.sv */
`default_nettype none
module ipav_queue
    import ipav_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_item i_push_item,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_item     o_pop_item
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != DEPTH_C);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/ipav_back.sv */
`default_nettype none
module ipav_back
    import ipav_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_item_valid,
    output logic       o_item_ready,
    input  wire t_item i_item,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_verdict   o_verdict
);

    typedef struct packed {
        t_parse_state st;
        logic         again;
    } t_pass;

    localparam t_parse_state RESET_ST = '{
        phase: PH_BEFORE, length: 3'd0, value: 9'd0, count: 4'd0, dcc: 2'd0
    };

    // Add one character to the current group
    function automatic t_parse_state f_append(t_parse_state s, t_item it);
        logic [11:0]  v;
        t_parse_state r;
        r = s;
        v = 12'(s.value) * 12'd10 + 12'(it.digit);
        if (s.length != LEN_MAX) begin
            r.length = s.length + 3'd1;
        end
        if (it.cls == CLS_DEC) begin
            r.value = (v > 12'(VALUE_MAX)) ? VALUE_SAT : v[8:0];
        end
        return r;
    endfunction

    // One examination of the character in the current phase
    function automatic t_pass f_pass(t_parse_state s, t_item it);
        t_pass r;
        logic  is_hex;
        r.st    = s;
        r.again = 1'b0;
        is_hex  = (it.cls == CLS_DEC) || (it.cls == CLS_HEXL);
        unique case (s.phase)
            PH_BEFORE: begin
                if ((it.cls == CLS_HEXL) || (it.cls == CLS_COLON)) begin
                    r.st.phase = PH_IPV6;
                    r.again    = 1'b1;
                end else if (it.cls == CLS_DEC) begin
                    r.st.phase = PH_ADDR;
                    r.again    = 1'b1;
                end else if (it.cls != CLS_SPACE) begin
                    r.st.phase = PH_ERROR;
                end
            end
            PH_ADDR: begin
                if (it.cls == CLS_HEXL) begin
                    r.st       = f_append(s, it);
                    r.st.phase = PH_IPV6;
                end else if (it.cls == CLS_DEC) begin
                    r.st = f_append(s, it);
                end else if (it.cls == CLS_DOT) begin
                    r.st.phase = PH_IPV4;
                    r.again    = 1'b1;
                end else if (it.cls == CLS_COLON) begin
                    r.st.phase = PH_IPV6;
                    r.again    = 1'b1;
                end else begin
                    r.st.phase = PH_ERROR;
                end
            end
            PH_IPV4: begin
                if (it.cls == CLS_DEC) begin
                    r.st = f_append(s, it);
                end else if ((it.cls == CLS_DOT) && (s.value <= VALUE_MAX)) begin
                    r.st.count  = s.count + 4'd1;
                    r.st.length = 3'd0;
                    r.st.value  = 9'd0;
                    if (r.st.count >= V4_GROUPS) begin
                        r.st.phase = PH_ERROR;
                    end
                end else begin
                    r.st.phase = PH_ERROR;
                end
            end
            PH_IPV6: begin
                if (is_hex) begin
                    r.st = f_append(s, it);
                end else if (it.cls == CLS_COLON) begin
                    if (s.length <= V6_GROUP_LEN) begin
                        r.st.count = s.count + 4'd1;
                        r.st.phase = (r.st.count < V6_GROUPS) ? PH_BETWEEN : PH_ERROR;
                    end else begin
                        r.st.phase = PH_ERROR;
                    end
                    r.st.length = 3'd0;
                    r.st.value  = 9'd0;
                end else if (it.cls != CLS_SPACE) begin
                    // a scope suffix lands here too
                    r.st.phase = PH_ERROR;
                end
            end
            PH_BETWEEN: begin
                if (is_hex) begin
                    r.st.phase = PH_IPV6;
                    r.again    = 1'b1;
                end else if (it.cls == CLS_COLON) begin
                    r.st.dcc = s.dcc + 2'd1;
                    if (r.st.dcc > DCC_MAX) begin
                        r.st.phase = PH_ERROR;
                    end
                end else if (it.cls != CLS_SPACE) begin
                    r.st.phase = PH_ERROR;
                end
            end
            default: begin
                r.st.phase = PH_ERROR;
            end
        endcase
        return r;
    endfunction

    // Check the pending group and pick the verdict
    function automatic t_verdict f_finish(t_parse_state s);
        t_phase     ph;
        logic [4:0] cnt;
        t_verdict   vd;
        ph  = s.phase;
        cnt = 5'(s.count);
        if ((ph != PH_ERROR) && (s.length != 3'd0)) begin
            if (ph == PH_IPV4) begin
                if (s.value > VALUE_MAX) begin
                    ph = PH_ERROR;
                end
                cnt = cnt + 5'd1;
                if (cnt > 5'(V4_GROUPS)) begin
                    ph = PH_ERROR;
                end
            end else if (ph == PH_IPV6) begin
                if (s.length > V6_GROUP_LEN) begin
                    ph = PH_ERROR;
                end
                cnt = cnt + 5'd1;
                if (cnt > 5'(V6_GROUPS)) begin
                    ph = PH_ERROR;
                end
            end else begin
                ph = PH_ERROR;
            end
        end
        case (ph) inside
            PH_BEFORE: vd = VD_EMPTY;
            PH_IPV4:   vd = (cnt == 5'(V4_GROUPS)) ? VD_IPV4_DONE : VD_IPV4_PART;
            PH_IPV6, PH_BETWEEN: begin
                vd = ((cnt == 5'(V6_GROUPS)) ||
                      ((cnt < 5'(V6_GROUPS)) && (s.dcc != 2'd0))) ?
                     VD_IPV6_DONE : VD_IPV6_PART;
            end
            default:   vd = VD_ERROR;
        endcase
        return vd;
    endfunction

    t_parse_state r_st;
    logic         r_out_valid;
    t_verdict     r_verdict;
    t_pass        n_pass1;
    t_pass        n_pass2;
    logic         is_end;
    logic         take;

    assign is_end       = (i_item.cls == CLS_END);
    assign o_item_ready = !is_end || !r_out_valid || i_out_ready;
    assign take         = i_item_valid && o_item_ready;
    assign o_out_valid  = r_out_valid;
    assign o_verdict    = r_verdict;

    // Run up to two phase examinations per character
    always_comb begin
        n_pass1 = f_pass(r_st, i_item);
        n_pass2 = n_pass1.again ? f_pass(n_pass1.st, i_item) : n_pass1;
    end

    // Update parser state and hold the verdict until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= RESET_ST;
            r_out_valid <= 1'b0;
        end else begin
            if (take && is_end) begin
                r_st        <= RESET_ST;
                r_out_valid <= 1'b1;
            end else begin
                if (take) begin
                    r_st <= n_pass2.st;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Load verdict payload
    always_ff @(posedge i_clk) begin
        if (take && is_end) begin
            r_verdict <= f_finish(r_st);
        end
    end

endmodule
`default_nettype wire

/* hdl/ip_address_text_validator.sv */
// Address text validator.
// Input channel (i_in_valid / o_in_ready): one ASCII character per item on
// i_character. An item with i_end_of_string high, or a NUL character, ends
// the string. Output channel (o_out_valid / i_out_ready): one verdict per
// string, on o_verdict: 0 empty, 1 IPv4 complete, 2 IPv4 incomplete,
// 3 IPv6 complete, 4 IPv6 incomplete, 5 error.
// A front stage classifies each character and writes it into a two-entry
// queue; the parser behind it takes one item per cycle from the queue and
// updates the phase and group counters; an end item waits while an earlier
// verdict is held. Throughput: one character per cycle while the output is
// not stalled. Output path: with nothing ahead of the end item in the queue,
// it passes the queue entry, then the verdict register, to raise o_out_valid.
// Reset clears the queue, the parser state and the output register; no item
// is pending afterward. When the receiver stalls, the verdict holds in the
// output register; the parser keeps taking characters of the next string
// and stops only at the next end item, after which the queue fills and
// o_in_ready drops.
`default_nettype none
module ip_address_text_validator
    import ipav_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_character,
    input  wire logic       i_end_of_string,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_verdict
);

    t_item    front_item;
    t_item    queue_item;
    logic     queue_valid;
    logic     queue_ready;
    t_verdict verdict;

    ipav_front u_front (
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .o_item          (front_item)
    );

    ipav_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    ipav_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (verdict)
    );

    assign o_verdict = verdict;

endmodule
`default_nettype wire
